[rtl/fdc_pkg.sv]
// ----------------------------------------------------------------------------
// fdc_pkg
// shared widths, codes and reset values of the frame deframer and checker
// ----------------------------------------------------------------------------
package fdc_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned POS_W    = 9;
	localparam int unsigned KIND_W   = 4;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned CFG_IDX_W = 2;

	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [POS_W-1:0]     pos_t;
	typedef logic [KIND_W-1:0]    kind_t;
	typedef logic [STATUS_W-1:0]  status_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam kind_t KIND_HEADER  = 4'd0;
	localparam kind_t KIND_ADDR1   = 4'd1;
	localparam kind_t KIND_ADDR2   = 4'd2;
	localparam kind_t KIND_COMMAND = 4'd3;
	localparam kind_t KIND_MSG_ID  = 4'd4;
	localparam kind_t KIND_LENGTH  = 4'd5;
	localparam kind_t KIND_DATA    = 4'd6;
	localparam kind_t KIND_CHECK   = 4'd7;
	localparam kind_t KIND_FOOTER  = 4'd8;
	localparam kind_t KIND_EXCESS  = 4'd9;

	localparam status_t STATUS_OK        = 3'd0;
	localparam status_t STATUS_SHORT     = 3'd1;
	localparam status_t STATUS_BAD_HDR   = 3'd2;
	localparam status_t STATUS_BAD_FTR   = 3'd3;
	localparam status_t STATUS_LEN_ERR   = 3'd4;

	localparam cfg_idx_t REG_HEADER    = 2'd0;
	localparam cfg_idx_t REG_FOOTER    = 2'd1;
	localparam cfg_idx_t REG_MIN_BYTES = 2'd2;

	localparam byte_t HEADER_RESET    = 8'd85;
	localparam byte_t FOOTER_RESET    = 8'd93;
	localparam pos_t  MIN_BYTES_RESET = 9'd8;

	localparam pos_t POS_MAX        = 9'd511;
	localparam pos_t POS_LENGTH     = 9'd5;
	localparam pos_t DATA_START     = 9'd6;
	localparam logic [POS_W:0] FRAME_OVERHEAD = 10'd8;

endpackage

[rtl/frame_deframer_checker_top.sv]
// ----------------------------------------------------------------------------
// frame_deframer_checker_top
// classifies frame bytes by position and gives the frame verdict on the last
// ----------------------------------------------------------------------------
// One byte enters per cycle while byte_stall is low and leaves as one result
// item: an input register, then the classification and checks, then a result
// register. The position, length byte and header match are kept in registers
// updated as each byte passes the result register, so back-to-back bytes of
// a frame flow at full rate unless result_stall holds them; the output
// register lets a new byte be taken while a finished result still waits. Data
// bytes are echoed before the verdict, which comes with the marked last byte
// (frame_end) as frame_status. Registers are written over the cfg port, which
// is always ready; writes to unknown indexes are dropped.
module frame_deframer_checker_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     byte_valid,
	output logic                     byte_stall,
	input  fdc_pkg::byte_t           byte_value,
	input  logic                     last_byte,
	output logic                     result_valid,
	input  logic                     result_stall,
	output fdc_pkg::kind_t           field_kind,
	output fdc_pkg::byte_t           field_value,
	output fdc_pkg::byte_t           data_index,
	output logic                     frame_end,
	output fdc_pkg::status_t         frame_status,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  fdc_pkg::cfg_idx_t        cfg_index,
	input  logic [fdc_pkg::POS_W-1:0] cfg_data
);
	import fdc_pkg::*;

	byte_t header_value_q;
	byte_t footer_value_q;
	pos_t  min_frame_bytes_q;

	logic  valid_s1;
	byte_t byte_s1;
	logic  last_s1;

	pos_t  byte_position_q;
	byte_t declared_length_q;
	logic  header_matched_q;

	logic  out_adv;
	logic  move_s1;
	logic  in_acc;

	logic            hdr_ok;
	byte_t           len_c;
	pos_t            data_end;
	logic [POS_W:0]  n_c;
	kind_t           kind_c;
	byte_t           idx_c;
	status_t         status_c;
	pos_t            idx_full;

	assign cfg_ready  = 1'b1;
	assign out_adv    = !result_valid || !result_stall;
	assign move_s1    = valid_s1 && out_adv;
	assign byte_stall = valid_s1 && !out_adv;
	assign in_acc     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_value_q    <= HEADER_RESET;
			footer_value_q    <= FOOTER_RESET;
			min_frame_bytes_q <= MIN_BYTES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HEADER:    header_value_q    <= cfg_data[BYTE_W-1:0];
				REG_FOOTER:    footer_value_q    <= cfg_data[BYTE_W-1:0];
				REG_MIN_BYTES: min_frame_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= byte_value;
			last_s1 <= last_byte;
		end
	end

	// classification and checks
	always_comb begin
		hdr_ok   = (byte_position_q == '0) ? (byte_s1 == header_value_q) : header_matched_q;
		len_c    = (byte_position_q == POS_LENGTH) ? byte_s1 : declared_length_q;
		data_end = DATA_START + {1'b0, len_c};
		n_c      = {1'b0, byte_position_q} + 10'd1;
		idx_full = byte_position_q - DATA_START;
		idx_c    = '0;
		if (byte_position_q < DATA_START) begin
			kind_c = byte_position_q[KIND_W-1:0];
		end else if (byte_position_q < data_end) begin
			kind_c = KIND_DATA;
			idx_c  = idx_full[BYTE_W-1:0];
		end else if (byte_position_q == data_end) begin
			kind_c = KIND_CHECK;
		end else if (byte_position_q == data_end + 9'd1) begin
			kind_c = KIND_FOOTER;
		end else begin
			kind_c = KIND_EXCESS;
		end
		priority if (!last_s1) begin
			status_c = STATUS_OK;
		end else if (n_c < {1'b0, min_frame_bytes_q}) begin
			status_c = STATUS_SHORT;
		end else if (!hdr_ok) begin
			status_c = STATUS_BAD_HDR;
		end else if (byte_s1 != footer_value_q) begin
			status_c = STATUS_BAD_FTR;
		end else if (n_c != {2'b00, len_c} + FRAME_OVERHEAD) begin
			status_c = STATUS_LEN_ERR;
		end else begin
			status_c = STATUS_OK;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q   <= '0;
			declared_length_q <= '0;
			header_matched_q  <= 1'b0;
		end else if (move_s1) begin
			if (last_s1) begin
				byte_position_q   <= '0;
				declared_length_q <= '0;
				header_matched_q  <= 1'b0;
			end else begin
				if (byte_position_q != POS_MAX) begin
					byte_position_q <= byte_position_q + 9'd1;
				end
				declared_length_q <= len_c;
				header_matched_q  <= hdr_ok;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_adv) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			field_kind   <= kind_c;
			field_value  <= byte_s1;
			data_index   <= idx_c;
			frame_end    <= last_s1;
			frame_status <= status_c;
		end
	end

	a_state_clears_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && last_s1) |=> (byte_position_q == '0 && !header_matched_q))
		else $error("frame state not cleared after last byte");

	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !frame_end) |-> (frame_status == STATUS_OK))
		else $error("verdict given before frame end");

	a_index_only_for_data: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && field_kind != KIND_DATA) |-> (data_index == '0))
		else $error("data index set on non-data byte");

	a_position_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && !last_s1 && byte_position_q != POS_MAX) |=>
		(byte_position_q == $past(byte_position_q) + 9'd1))
		else $error("byte position did not advance");

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for frame_deframer_checker_top
// ----------------------------------------------------------------------------
// A frame tracker class follows every accepted byte with its own copy of the
// position, length byte and header match, and queues the field it expects.
// Each result item is compared field by field with the oldest one queued.
// Short directed frames come first, then phases of register settings, each
// with random frames: mostly well formed, the rest with bad header, bad
// footer, cut short, padded, wrong length byte, noise; one phase also has a
// frame long enough to saturate the position. The sender works in random
// bursts and the receiver stalls in random runs, with one phase at full rate.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fdc_pkg::*;

	localparam cfg_idx_t REG_UNUSED   = 2'd3;
	localparam int       CYCLE_LIMIT  = 400000;
	localparam int       DRAIN_CYCLES = 8;
	localparam int       PHASE_BYTES  = 180;
	localparam int       MAX_REPORTS  = 10;

	typedef struct packed {
		kind_t   kind;
		byte_t   value;
		byte_t   didx;
		logic    fend;
		status_t status;
	} field_rec_t;

	class frame_tracker;
		byte_t      hdr_val = HEADER_RESET;
		byte_t      ftr_val = FOOTER_RESET;
		pos_t       min_len = MIN_BYTES_RESET;
		pos_t       pos     = '0;
		byte_t      dlen    = '0;
		bit         hdr_ok  = 1'b0;
		field_rec_t expected_fields[$];
		int         mismatches = 0;

		function void write_reg(cfg_idx_t idx, pos_t data);
			case (idx)
				REG_HEADER:    hdr_val = data[BYTE_W-1:0];
				REG_FOOTER:    ftr_val = data[BYTE_W-1:0];
				REG_MIN_BYTES: min_len = data;
				default: ;
			endcase
		endfunction

		function void take_byte(byte_t b, logic last);
			field_rec_t  f;
			int unsigned p;
			int unsigned dl;
			int unsigned n;
			p = pos;
			if (p == 0) begin
				hdr_ok = (b == hdr_val);
			end
			if (p == POS_LENGTH) begin
				dlen = b;
			end
			dl = dlen;
			f.value  = b;
			f.didx   = '0;
			f.fend   = last;
			f.status = STATUS_OK;
			if (p < DATA_START) begin
				case (p)
					0: f.kind = KIND_HEADER;
					1: f.kind = KIND_ADDR1;
					2: f.kind = KIND_ADDR2;
					3: f.kind = KIND_COMMAND;
					4: f.kind = KIND_MSG_ID;
					default: f.kind = KIND_LENGTH;
				endcase
			end else if (p < DATA_START + dl) begin
				f.kind = KIND_DATA;
				f.didx = byte_t'(p - DATA_START);
			end else if (p == DATA_START + dl) begin
				f.kind = KIND_CHECK;
			end else if (p == DATA_START + dl + 1) begin
				f.kind = KIND_FOOTER;
			end else begin
				f.kind = KIND_EXCESS;
			end
			if (last) begin
				n = p + 1;
				if (n < min_len) begin
					f.status = STATUS_SHORT;
				end else if (!hdr_ok) begin
					f.status = STATUS_BAD_HDR;
				end else if (b != ftr_val) begin
					f.status = STATUS_BAD_FTR;
				end else if (n != dl + FRAME_OVERHEAD) begin
					f.status = STATUS_LEN_ERR;
				end
				pos    = '0;
				dlen   = '0;
				hdr_ok = 1'b0;
			end else if (p < POS_MAX) begin
				pos = pos + 1'b1;
			end
			expected_fields.push_back(f);
		endfunction

		function void compare_fields(field_rec_t got);
			field_rec_t want;
			if (expected_fields.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("unexpected item: kind %0d value %0h index %0d end %0b status %0d",
						got.kind, got.value, got.didx, got.fend, got.status);
				end
				return;
			end
			want = expected_fields.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("mismatch: expected kind %0d value %0h index %0d end %0b status %0d",
						want.kind, want.value, want.didx, want.fend, want.status);
					$display("          got      kind %0d value %0h index %0d end %0b status %0d",
						got.kind, got.value, got.didx, got.fend, got.status);
				end
			end
		endfunction
	endclass

	logic     clk          = 1'b0;
	logic     arst_n       = 1'b0;
	logic     byte_valid   = 1'b0;
	byte_t    byte_value   = '0;
	logic     last_byte    = 1'b0;
	logic     result_stall = 1'b0;
	logic     cfg_valid    = 1'b0;
	cfg_idx_t cfg_index    = '0;
	pos_t     cfg_data     = '0;

	logic     byte_stall;
	logic     result_valid;
	kind_t    field_kind;
	byte_t    field_value;
	byte_t    data_index;
	logic     frame_end;
	status_t  frame_status;
	logic     cfg_ready;

	frame_tracker trk = new();

	byte_t frame_buf[$];
	byte_t hdr_cfg     = HEADER_RESET;
	byte_t ftr_cfg     = FOOTER_RESET;
	bit    steady      = 1'b0;
	int    burst_left  = 0;
	int    phase_bytes = 0;
	int    stall_left  = 0;
	int    go_left     = 0;

	frame_deframer_checker_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_value   (byte_value),
		.last_byte    (last_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.field_kind   (field_kind),
		.field_value  (field_value),
		.data_index   (data_index),
		.frame_end    (frame_end),
		.frame_status (frame_status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// sample handshakes and pace the receiver
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) begin
			trk.write_reg(cfg_index, cfg_data);
		end
		if (byte_valid && !byte_stall) begin
			trk.take_byte(byte_value, last_byte);
		end
		if (result_valid && !result_stall) begin
			trk.compare_fields(field_rec_t'({field_kind, field_value, data_index,
				frame_end, frame_status}));
		end
		if (steady) begin
			result_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (go_left > 0) begin
			go_left--;
			result_stall <= 1'b0;
		end else begin
			stall_left = $urandom_range(0, 6);
			go_left    = $urandom_range(1, 12);
			result_stall <= 1'b0;
		end
	end

	initial begin
		for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
		$display("FAIL frame_deframer_checker_top");
		$finish;
	end

	task automatic send_byte(byte_t b, logic last);
		int gap;
		if (!steady) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = $urandom_range(0, 8);
				if (gap > 0) begin
					byte_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		byte_valid <= 1'b1;
		byte_value <= b;
		last_byte  <= last;
		do @(posedge clk); while (byte_stall);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++) begin
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		end
		phase_bytes += frame_buf.size();
	endtask

	task automatic build_frame(int dl);
		frame_buf = {};
		frame_buf.push_back(hdr_cfg);
		repeat (4) frame_buf.push_back(byte_t'($urandom));
		frame_buf.push_back(byte_t'(dl));
		repeat (dl) frame_buf.push_back(byte_t'($urandom));
		frame_buf.push_back(byte_t'($urandom));
		frame_buf.push_back(ftr_cfg);
	endtask

	task automatic random_frame();
		int r;
		int dl;
		int cut;
		r  = $urandom_range(0, 99);
		dl = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 16);
		build_frame(dl);
		if (r < 55) begin
		end else if (r < 65) begin
			frame_buf[0] = hdr_cfg ^ byte_t'($urandom_range(1, 255));
		end else if (r < 73) begin
			frame_buf[frame_buf.size() - 1] = ftr_cfg ^ byte_t'($urandom_range(1, 255));
		end else if (r < 82) begin
			cut = $urandom_range(1, frame_buf.size() - 1);
			frame_buf = frame_buf[0:cut-1];
		end else if (r < 88) begin
			repeat ($urandom_range(1, 5))
				frame_buf.insert(frame_buf.size() - 1, byte_t'($urandom));
		end else if (r < 93) begin
			frame_buf[POS_LENGTH] = byte_t'(dl) ^ byte_t'($urandom_range(1, 255));
		end else begin
			frame_buf = {};
			repeat ($urandom_range(1, 12)) frame_buf.push_back(byte_t'($urandom));
		end
		send_frame();
	endtask

	task automatic wait_drained();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (trk.expected_fields.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(pos_t hv, pos_t fv, pos_t mv);
		cfg_idx_t idxs[4];
		pos_t     vals[4];
		idxs = '{REG_HEADER, REG_FOOTER, REG_MIN_BYTES, REG_UNUSED};
		vals = '{hv, fv, mv, pos_t'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idxs[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		hdr_cfg = hv[BYTE_W-1:0];
		ftr_cfg = fv[BYTE_W-1:0];
	endtask

	initial begin
		pos_t shared;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single byte, minimal good frame, one data byte, early end
		frame_buf = '{HEADER_RESET};
		send_frame();
		frame_buf = '{HEADER_RESET, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, FOOTER_RESET};
		send_frame();
		frame_buf = '{HEADER_RESET, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'h00,
			FOOTER_RESET};
		send_frame();
		frame_buf = '{8'h00, 8'hFF, FOOTER_RESET};
		send_frame();

		for (int ph = 0; ph < 7; ph++) begin
			wait_drained();
			shared = pos_t'($urandom);
			case (ph)
				1: set_regs(9'h100, 9'h0FF, 9'd6);
				2: set_regs(9'h0FF, 9'h100, 9'd263);
				3: set_regs(shared, shared, 9'd0);
				4: set_regs(pos_t'($urandom), pos_t'($urandom), 9'd511);
				5: set_regs(pos_t'($urandom), pos_t'($urandom), pos_t'($urandom_range(1, 20)));
				6: set_regs(pos_t'(HEADER_RESET), pos_t'(FOOTER_RESET), MIN_BYTES_RESET);
				default: ;
			endcase
			steady = (ph == 2);
			phase_bytes = 0;
			frame_buf = '{hdr_cfg};
			send_frame();
			if (ph == 4) begin
				// long enough for the position to saturate
				build_frame(0);
				repeat (522) frame_buf.insert(frame_buf.size() - 1, byte_t'($urandom));
				send_frame();
			end
			while (phase_bytes < PHASE_BYTES) random_frame();
		end

		wait_drained();
		if (trk.mismatches == 0) begin
			$display("PASS frame_deframer_checker_top");
		end else begin
			$display("FAIL frame_deframer_checker_top");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/fdc_pkg.sv
rtl/frame_deframer_checker_top.sv
tb/sv/tb.sv
